### rtl/core/rgb_edge_detect_3x3_assert.svh
// assertion macros for the rgb 3x3 edge detector
`ifndef RGB_EDGE_DETECT_3X3_ASSERT_SVH
`define RGB_EDGE_DETECT_3X3_ASSERT_SVH

// same-cycle implication, checked on i_clk outside reset
`define E3_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define E3_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/edge3x3_pkg.sv
// shared types, constants and kernel tables of the rgb 3x3 edge detector
`timescale 1ns / 1ps
`default_nettype none

package edge3x3_pkg;

    // default size limits of the line memory and the row counter
    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    // field widths
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned FW_BITS    = 12;
    localparam int unsigned FH_BITS    = 13;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef logic [PIX_W-1:0]   t_chan;
    typedef logic [3*PIX_W-1:0] t_pixel;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE         = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_idx;

    // detector modes
    localparam logic MODE_DIFF   = 1'b0;
    localparam logic MODE_KIRSCH = 1'b1;

    // register values after reset
    localparam logic               MODE_RESET = MODE_DIFF;
    localparam logic [FW_BITS-1:0] FW_RESET   = 12'd640;
    localparam logic [FH_BITS-1:0] FH_RESET   = 13'd480;

    // divide by 3 as (x * 683) >> 11, exact for x below 2048
    localparam logic [9:0] DIV3_RECIP = 10'd683;
    localparam int unsigned DIV3_SHIFT = 11;

    // clamp limit of the kirsch result
    localparam logic [PIX_W-1:0] CHAN_MAX = 8'd255;

    // neighbour index sets, window numbered 0..8 row-major, 4 the center
    localparam logic [3:0] DIFF_SETS [4][6] = '{
        '{4'd0, 4'd1, 4'd2, 4'd6, 4'd7, 4'd8},
        '{4'd0, 4'd3, 4'd6, 4'd2, 4'd5, 4'd8},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8},
        '{4'd1, 4'd2, 4'd5, 4'd3, 4'd6, 4'd7}
    };

    localparam logic [3:0] KIRSCH_PLUS [8][3] = '{
        '{4'd0, 4'd1, 4'd2}, '{4'd1, 4'd2, 4'd5}, '{4'd2, 4'd5, 4'd8}, '{4'd5, 4'd7, 4'd8},
        '{4'd6, 4'd7, 4'd8}, '{4'd3, 4'd6, 4'd7}, '{4'd0, 4'd3, 4'd6}, '{4'd0, 4'd1, 4'd3}
    };

    // border handling of one pixel's neighbourhood
    typedef struct packed {
        logic c1;     // column 1: left column repeats
        logic clast;  // last column: a second result repeats the right column
        logic r1;     // row 1: top row repeats
        logic rlast;  // last row: a second result repeats the bottom row
    } t_plan;

    // markers that travel with each result word
    typedef struct packed {
        logic last;
        logic eof;
    } t_tag;

endpackage

`default_nettype wire

### rtl/core/edge3x3_pix_if.sv
// pixel input channel: valid, ready and one rgb pixel
`timescale 1ns / 1ps
`default_nettype none

interface edge3x3_pix_if
    import edge3x3_pkg::*;
();
    logic  valid;
    logic  ready;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                     input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                     output ready);
endinterface

`default_nettype wire

### rtl/core/edge3x3_res_if.sv
// result output channel: valid, ready and one edge strength word
`timescale 1ns / 1ps
`default_nettype none

interface edge3x3_res_if
    import edge3x3_pkg::*;
();
    logic  valid;
    logic  ready;
    t_chan red_out;
    t_chan green_out;
    t_chan blue_out;
    logic  last_of_run;
    logic  end_of_frame;

    modport source (output valid, output red_out, output green_out, output blue_out,
                     output last_of_run, output end_of_frame, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                     input last_of_run, input end_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/core/rgb_edge_detect_3x3.sv
// RGB 3x3 edge detector (directional difference or Kirsch compass), streaming.
// Pixels enter in raster order at up to one per clock; the two previous rows
// sit in one line memory of MAX_WIDTH x 48 bits (upper and lower row side by
// side), read in the cycle before the window update and written back at the
// same column, one read and one write per pixel. Each result word carries the
// edge strength of the pixel one row and one column back; the left/top
// borders repeat the nearest pixel. Rows 1 .. H-2 give one word per pixel
// (none in row 0 and column 0, two in the last column). In the last row each
// pixel past column 0 gives two words and the last pixel of the frame four, so
// there the input is held back until the single result port has taken them.
// The line memory needs no clearing after reset: stale data read in rows 0
// and 1 is never used, as row 0 gives no words and row 1 repeats its top row.
// Write the configuration only while the block is idle; frame sizes are
// clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT.
`timescale 1ns / 1ps
`default_nettype none

module rgb_edge_detect_3x3
    import edge3x3_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    edge3x3_pix_if.sink           i_pix,
    edge3x3_res_if.source         o_res
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned WW = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;
    localparam int unsigned HW = (RW + 1 > FH_BITS) ? RW + 1 : FH_BITS;

    // configuration registers
    logic               r_mode;
    logic [FW_BITS-1:0] r_fw;
    logic [FH_BITS-1:0] r_fh;

    // raster position
    logic [CW-1:0] r_col, n_col, c_cur;
    logic [RW-1:0] r_row, n_row, r_cur;
    logic [WW-1:0] w_eff, fw_ext;
    logic [HW-1:0] h_eff, fh_ext, row_pre;
    logic          col_wrap, c_last, r_last, emit_cur;

    // read stage
    logic          r_s1_valid;
    t_pixel        r_s1_px;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_emit;
    t_plan         r_s1_plan;
    logic          s1_adv, in_fire;

    // line memory
    logic [6*PIX_W-1:0] r_line_mem [MAX_WIDTH];
    logic [6*PIX_W-1:0] r_line_q;
    logic [CW-1:0]      rd_addr;

    // window, [row][column], column 2 the newest
    t_pixel r_win [3][3];

    // result sequencer
    logic  r_em_valid;
    logic  r_em_cidx;
    logic  r_em_ridx;
    t_plan r_em_plan;
    logic  em_fire, em_last_step, em_done;
    t_pixel sel_cols [3][3];
    t_pixel nb_px [3][3];

    // compute pipeline
    logic  r_p1_valid, r_p2_valid, r_p3_valid, r_o_valid;
    t_tag  r_p1_tag, r_p2_tag, r_p3_tag, r_o_tag;
    logic  rdy_p1, rdy_p2, rdy_p3, rdy_o;
    t_chan r_p1_nb [3][9];
    t_chan res_ch [3];
    t_chan r_o_ch [3];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_fw   <= FW_RESET;
            r_fh   <= FH_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:         r_mode <= i_cfg_data[0];
                CFG_FRAME_WIDTH:  r_fw   <= i_cfg_data[FW_BITS-1:0];
                CFG_FRAME_HEIGHT: r_fh   <= i_cfg_data[FH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        fw_ext = WW'(r_fw);
        fh_ext = HW'(r_fh);
        if (fw_ext < WW'(2)) begin
            w_eff = WW'(2);
        end else if (fw_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        if (fh_ext < HW'(2)) begin
            h_eff = HW'(2);
        end else if (fh_ext > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = fh_ext;
        end
    end

    // position of the incoming pixel, wrapping a count beyond a shrunk size
    always_comb begin
        col_wrap = WW'(r_col) >= w_eff;
        row_pre  = HW'(r_row) + (col_wrap ? HW'(1) : HW'(0));
        c_cur    = col_wrap ? '0 : r_col;
        r_cur    = (row_pre >= h_eff) ? '0 : row_pre[RW-1:0];
        c_last   = WW'(c_cur) == (w_eff - WW'(1));
        r_last   = HW'(r_cur) == (h_eff - HW'(1));
        emit_cur = (r_cur != '0) && (c_cur != '0);
        n_col    = c_last ? '0 : c_cur + CW'(1);
        if (c_last) begin
            n_row = r_last ? '0 : r_cur + RW'(1);
        end else begin
            n_row = r_cur;
        end
    end

    // handshake of the input side
    assign s1_adv      = r_s1_valid && (!r_em_valid || em_done);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_fire     = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_px         <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_s1_col        <= c_cur;
            r_s1_emit       <= emit_cur;
            r_s1_plan.c1    <= c_cur == CW'(1);
            r_s1_plan.clast <= c_last;
            r_s1_plan.r1    <= r_cur == RW'(1);
            r_s1_plan.rlast <= r_last;
        end
    end

    // line memory: a stalled pixel keeps re-reading its column, so the read
    // data stays valid; back-to-back pixels never share a column (width >= 2)
    assign rd_addr = (r_s1_valid && !s1_adv) ? r_s1_col : c_cur;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_line_mem[r_s1_col] <= {r_line_q[3*PIX_W-1:0], r_s1_px};
        end
        r_line_q <= r_line_mem[rd_addr];
    end

    // window shift with the new column
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_line_q[6*PIX_W-1:3*PIX_W];
            r_win[1][2] <= r_line_q[3*PIX_W-1:0];
            r_win[2][2] <= r_s1_px;
        end
    end

    // result sequencer: columns outer, rows inner
    assign em_last_step = (r_em_ridx == r_em_plan.rlast) && (r_em_cidx == r_em_plan.clast);
    assign em_fire      = r_em_valid && rdy_p1;
    assign em_done      = em_fire && em_last_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid <= 1'b0;
            r_em_cidx  <= 1'b0;
            r_em_ridx  <= 1'b0;
        end else if (s1_adv) begin
            r_em_valid <= r_s1_emit;
            r_em_cidx  <= 1'b0;
            r_em_ridx  <= 1'b0;
        end else if (em_fire) begin
            if (em_last_step) begin
                r_em_valid <= 1'b0;
            end else if (r_em_ridx != r_em_plan.rlast) begin
                r_em_ridx <= 1'b1;
            end else begin
                r_em_ridx <= 1'b0;
                r_em_cidx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_em_plan <= r_s1_plan;
        end
    end

    // neighbourhood with repeated border rows and columns
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sel_cols[i][0] = (r_em_cidx || r_em_plan.c1) ? r_win[i][1] : r_win[i][0];
            sel_cols[i][1] = r_em_cidx ? r_win[i][2] : r_win[i][1];
            sel_cols[i][2] = r_win[i][2];
        end
        for (int j = 0; j < 3; j++) begin
            nb_px[0][j] = (r_em_ridx || r_em_plan.r1) ? sel_cols[1][j] : sel_cols[0][j];
            nb_px[1][j] = r_em_ridx ? sel_cols[2][j] : sel_cols[1][j];
            nb_px[2][j] = sel_cols[2][j];
        end
    end

    // pipeline flow: a stage moves when it is empty or its successor moves
    assign rdy_o  = !r_o_valid || o_res.ready;
    assign rdy_p3 = !r_p3_valid || rdy_o;
    assign rdy_p2 = !r_p2_valid || rdy_p3;
    assign rdy_p1 = !r_p1_valid || rdy_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (rdy_p1) r_p1_valid <= r_em_valid;
            if (rdy_p2) r_p2_valid <= r_p1_valid;
            if (rdy_p3) r_p3_valid <= r_p2_valid;
            if (rdy_o)  r_o_valid  <= r_p3_valid;
        end
    end

    // markers and neighbourhood into the first compute stage
    always_ff @(posedge i_clk) begin
        if (rdy_p1) begin
            r_p1_tag.last <= em_last_step;
            r_p1_tag.eof  <= em_last_step && r_em_plan.clast && r_em_plan.rlast;
            for (int ch = 0; ch < 3; ch++) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_p1_nb[ch][i*3+j] <= nb_px[i][j][(3-ch)*PIX_W-1 -: PIX_W];
                    end
                end
            end
        end
        if (rdy_p2) r_p2_tag <= r_p1_tag;
        if (rdy_p3) r_p3_tag <= r_p2_tag;
        if (rdy_o) begin
            r_o_tag <= r_p3_tag;
            for (int ch = 0; ch < 3; ch++) begin
                r_o_ch[ch] <= res_ch[ch];
            end
        end
    end

    // per-channel kernel datapath
    for (genvar g = 0; g < 3; g++) begin : g_chan
        logic        [9:0]  d_c [4];
        logic signed [13:0] v_c [8];
        logic        [9:0]  r_p2_d [4];
        logic signed [13:0] r_p2_v [8];
        logic        [9:0]  m0_c;
        logic signed [13:0] ma_c, mb_c;
        logic        [9:0]  r_p3_m0;
        logic signed [13:0] r_p3_ma, r_p3_mb;
        logic signed [13:0] mx;
        logic        [19:0] prod;
        t_chan              k1;

        // sums of three, differences and kirsch responses
        always_comb begin : p2_math
            logic [9:0]  a;
            logic [9:0]  b;
            logic [9:0]  p;
            logic [10:0] sum8;
            logic [12:0] sum8x3;
            sum8 = '0;
            for (int n = 0; n < 9; n++) begin
                if (n != 4) sum8 = sum8 + 11'(r_p1_nb[g][n]);
            end
            sum8x3 = 13'({sum8, 1'b0}) + 13'(sum8);
            for (int k = 0; k < 4; k++) begin
                a = 10'(r_p1_nb[g][DIFF_SETS[k][0]]) + 10'(r_p1_nb[g][DIFF_SETS[k][1]])
                  + 10'(r_p1_nb[g][DIFF_SETS[k][2]]);
                b = 10'(r_p1_nb[g][DIFF_SETS[k][3]]) + 10'(r_p1_nb[g][DIFF_SETS[k][4]])
                  + 10'(r_p1_nb[g][DIFF_SETS[k][5]]);
                d_c[k] = (a >= b) ? a - b : b - a;
            end
            // 5*plus - 3*(others) = 8*plus - 3*(all eight)
            for (int k = 0; k < 8; k++) begin
                p = 10'(r_p1_nb[g][KIRSCH_PLUS[k][0]]) + 10'(r_p1_nb[g][KIRSCH_PLUS[k][1]])
                  + 10'(r_p1_nb[g][KIRSCH_PLUS[k][2]]);
                v_c[k] = $signed({1'b0, p, 3'b000}) - $signed({1'b0, sum8x3});
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy_p2) begin
                r_p2_d <= d_c;
                r_p2_v <= v_c;
            end
        end

        // first two levels of the maximum trees
        always_comb begin : p3_max
            logic        [9:0]  d01;
            logic        [9:0]  d23;
            logic signed [13:0] v01;
            logic signed [13:0] v23;
            logic signed [13:0] v45;
            logic signed [13:0] v67;
            d01  = (r_p2_d[0] > r_p2_d[1]) ? r_p2_d[0] : r_p2_d[1];
            d23  = (r_p2_d[2] > r_p2_d[3]) ? r_p2_d[2] : r_p2_d[3];
            m0_c = (d01 > d23) ? d01 : d23;
            v01  = (r_p2_v[0] > r_p2_v[1]) ? r_p2_v[0] : r_p2_v[1];
            v23  = (r_p2_v[2] > r_p2_v[3]) ? r_p2_v[2] : r_p2_v[3];
            v45  = (r_p2_v[4] > r_p2_v[5]) ? r_p2_v[4] : r_p2_v[5];
            v67  = (r_p2_v[6] > r_p2_v[7]) ? r_p2_v[6] : r_p2_v[7];
            ma_c = (v01 > v23) ? v01 : v23;
            mb_c = (v45 > v67) ? v45 : v67;
        end

        always_ff @(posedge i_clk) begin
            if (rdy_p3) begin
                r_p3_m0 <= m0_c;
                r_p3_ma <= ma_c;
                r_p3_mb <= mb_c;
            end
        end

        // divide by 3 of the largest difference, or clamp of the kirsch peak
        always_comb begin
            prod = 20'(r_p3_m0) * 20'(DIV3_RECIP);
            mx   = (r_p3_ma > r_p3_mb) ? r_p3_ma : r_p3_mb;
            if (mx < 14'sd0) begin
                k1 = '0;
            end else if (mx > $signed({6'b0, CHAN_MAX})) begin
                k1 = CHAN_MAX;
            end else begin
                k1 = mx[PIX_W-1:0];
            end
            res_ch[g] = (r_mode == MODE_KIRSCH) ? k1 : prod[DIV3_SHIFT +: PIX_W];
        end
    end

    // result channel
    assign o_res.valid        = r_o_valid;
    assign o_res.red_out      = r_o_ch[0];
    assign o_res.green_out    = r_o_ch[1];
    assign o_res.blue_out     = r_o_ch[2];
    assign o_res.last_of_run  = r_o_tag.last;
    assign o_res.end_of_frame = r_o_tag.eof;

    // checks
`include "rgb_edge_detect_3x3_assert.svh"

    `E3_AST_NXT(a_s1_hold, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_col), "read stage lost its column while stalled")
    `E3_AST_IMP(a_em_order, r_em_valid && !r_em_plan.clast, !r_em_cidx, "second column word outside the last column")
    `E3_AST_IMP(a_eof_last, r_o_valid && r_o_tag.eof, r_o_tag.last, "end of frame not on the last word of its pixel")
    `E3_AST_NXT(a_p1_hold, r_p1_valid && !rdy_p2, r_p1_valid && $stable(r_p1_tag), "first compute stage dropped a stalled word")

endmodule

`default_nettype wire
